>>> rtl/core/bumsort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bumsort_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_WIDTH = 32;

	// store index, batch count, and sums of start plus run widths
	localparam int IDX_W = $clog2(MAX_KEYS);
	localparam int CNT_W = $clog2(MAX_KEYS + 1);
	localparam int SUM_W = $clog2(3 * MAX_KEYS);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS = 1'd1;

	typedef struct packed {
		logic [31:0] key_value;
		logic        key_last;
	} key_item_t;

	typedef struct packed {
		logic [31:0] sorted_value;
		logic        sorted_last;
	} sorted_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS,
		ST_PRIME,
		ST_MERGE,
		ST_OUT_PRIME,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic sort_init;
		logic seg_prime;
		logic merge_step;
		logic pass_next;
		logic out_init;
		logic out_push;
	} dp_cmd_t;

	typedef struct packed {
		logic load_end;
		logic sort_done;
		logic seg_last;
		logic pass_last;
		logic out_last;
	} dp_stat_t;

	function automatic logic [KEY_WIDTH-1:0] to_key(input logic [31:0] v);
		logic [63:0] t;
		t = {32'b0, v};
		return t[KEY_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] from_key(input logic [KEY_WIDTH-1:0] k);
		logic [63:0] t;
		t = 64'(k);
		return t[31:0];
	endfunction

	// true when a may precede b; ties favor a
	function automatic logic goes_first(
		input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b,
		input logic                 desc,
		input logic                 sgn
	);
		logic [KEY_WIDTH-1:0] s;
		logic [KEY_WIDTH-1:0] x;
		logic [KEY_WIDTH-1:0] y;
		s = KEY_WIDTH'(1) << (KEY_WIDTH - 1);
		x = a ^ (sgn ? s : '0);
		y = b ^ (sgn ? s : '0);
		return desc ? (x >= y) : (x <= y);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bumsort_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bumsort_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 key_valid,
	output logic                      key_stall,
	input  wire logic                 out_room,
	input  wire bumsort_pkg::dp_stat_t stat,
	output bumsort_pkg::dp_cmd_t      cmd
);

	bumsort_pkg::state_t state_q;
	bumsort_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bumsort_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		key_stall = 1'b1;
		unique case (state_q)
			bumsort_pkg::ST_LOAD: begin
				key_stall = 1'b0;
				if (key_valid) begin
					cmd.load = 1'b1;
					if (stat.load_end) begin
						cmd.sort_init = 1'b1;
						state_d       = bumsort_pkg::ST_PASS;
					end
				end
			end
			bumsort_pkg::ST_PASS: begin
				if (stat.sort_done) begin
					state_d = bumsort_pkg::ST_OUT_PRIME;
				end else begin
					state_d = bumsort_pkg::ST_PRIME;
				end
			end
			bumsort_pkg::ST_PRIME: begin
				cmd.seg_prime = 1'b1;
				state_d       = bumsort_pkg::ST_MERGE;
			end
			bumsort_pkg::ST_MERGE: begin
				cmd.merge_step = 1'b1;
				if (stat.seg_last) begin
					if (stat.pass_last) begin
						cmd.pass_next = 1'b1;
						state_d       = bumsort_pkg::ST_PASS;
					end else begin
						state_d = bumsort_pkg::ST_PRIME;
					end
				end
			end
			bumsort_pkg::ST_OUT_PRIME: begin
				cmd.out_init = 1'b1;
				state_d      = bumsort_pkg::ST_OUT;
			end
			bumsort_pkg::ST_OUT: begin
				if (out_room) begin
					cmd.out_push = 1'b1;
					if (stat.out_last) begin
						state_d = bumsort_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				state_d = bumsort_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/bumsort_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bumsort_dp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bumsort_pkg::dp_cmd_t     cmd,
	input  wire bumsort_pkg::key_item_t   key,
	input  wire logic                     descending,
	input  wire logic                     signed_keys,
	output bumsort_pkg::dp_stat_t         stat,
	output bumsort_pkg::sorted_item_t     rd_item
);

	localparam int IW = bumsort_pkg::IDX_W;
	localparam int CW = bumsort_pkg::CNT_W;
	localparam int SW = bumsort_pkg::SUM_W;
	localparam int KW = bumsort_pkg::KEY_WIDTH;
	localparam int NK = bumsort_pkg::MAX_KEYS;

	// ping-pong buffers; each pass merges from src into the other one
	logic [KW-1:0] buf0 [NK];
	logic [KW-1:0] buf1 [NK];

	logic [KW-1:0] ra0_q, rb0_q, ra1_q, rb1_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] width_q;
	logic [CW-1:0] start_q, mid_q, hi_q, i_q, j_q, k_q;
	logic          src_q;

	logic [SW-1:0] seg_mid_w, seg_hi_w;
	logic [CW-1:0] seg_mid, seg_hi;
	logic [KW-1:0] head_a, head_b, wr_val;
	logic          a_ok, b_ok, take_a;
	logic [CW-1:0] i_nx, j_nx;
	logic [IW-1:0] addr_a, addr_b;

	assign seg_mid_w = SW'(start_q) + width_q;
	assign seg_hi_w  = seg_mid_w + width_q;
	assign seg_mid   = (seg_mid_w >= SW'(cnt_q)) ? cnt_q : seg_mid_w[CW-1:0];
	assign seg_hi    = (seg_hi_w >= SW'(cnt_q)) ? cnt_q : seg_hi_w[CW-1:0];

	assign head_a = src_q ? ra1_q : ra0_q;
	assign head_b = src_q ? rb1_q : rb0_q;

	assign a_ok   = i_q < mid_q;
	assign b_ok   = j_q < hi_q;
	assign take_a = !b_ok ||
		(a_ok && bumsort_pkg::goes_first(head_a, head_b, descending, signed_keys));
	assign wr_val = take_a ? head_a : head_b;
	assign i_nx   = take_a ? i_q + CW'(1) : i_q;
	assign j_nx   = take_a ? j_q : j_q + CW'(1);

	// next read addresses, so the heads are ready in the next cycle
	always_comb begin
		addr_a = k_q[IW-1:0];
		addr_b = j_q[IW-1:0];
		if (cmd.seg_prime) begin
			addr_a = start_q[IW-1:0];
			addr_b = seg_mid[IW-1:0];
		end else if (cmd.merge_step) begin
			addr_a = i_nx[IW-1:0];
			addr_b = j_nx[IW-1:0];
		end else if (cmd.out_init) begin
			addr_a = '0;
		end else if (cmd.out_push) begin
			addr_a = k_q[IW-1:0] + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		ra0_q <= buf0[addr_a];
		rb0_q <= buf0[addr_b];
		ra1_q <= buf1[addr_a];
		rb1_q <= buf1[addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf0[cnt_q[IW-1:0]] <= bumsort_pkg::to_key(key.key_value);
		end else if (cmd.merge_step && src_q) begin
			buf0[k_q[IW-1:0]] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.merge_step && !src_q) begin
			buf1[k_q[IW-1:0]] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			width_q <= '0;
			start_q <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			src_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.sort_init) begin
				width_q <= SW'(1);
				start_q <= '0;
				src_q   <= 1'b0;
			end
			if (cmd.seg_prime) begin
				i_q   <= start_q;
				j_q   <= seg_mid;
				k_q   <= start_q;
				mid_q <= seg_mid;
				hi_q  <= seg_hi;
			end
			if (cmd.merge_step) begin
				i_q <= i_nx;
				j_q <= j_nx;
				k_q <= k_q + CW'(1);
				if (stat.seg_last) begin
					start_q <= hi_q;
				end
			end
			// overrides the segment advance on the last transfer of a pass
			if (cmd.pass_next) begin
				width_q <= width_q << 1;
				start_q <= '0;
				src_q   <= ~src_q;
			end
			if (cmd.out_init) begin
				k_q <= '0;
			end
			if (cmd.out_push) begin
				k_q <= k_q + CW'(1);
				if (stat.out_last) begin
					cnt_q <= '0;
				end
			end
		end
	end

	assign stat.load_end  = key.key_last || (cnt_q == CW'(NK - 1));
	assign stat.sort_done = width_q >= SW'(cnt_q);
	assign stat.seg_last  = (SW'(k_q) + SW'(1)) == SW'(hi_q);
	assign stat.pass_last = hi_q == cnt_q;
	assign stat.out_last  = (SW'(k_q) + SW'(1)) == SW'(cnt_q);

	assign rd_item.sorted_value = bumsort_pkg::from_key(head_a);
	assign rd_item.sorted_last  = stat.out_last;

`ifndef ASSERT_OFF
	a_write_in_segment: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_step |-> (k_q < hi_q))
		else $error("merge write beyond segment end");

	a_merge_bookkeeping: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_step |-> (SW'(k_q) + SW'(mid_q) == SW'(i_q) + SW'(j_q)))
		else $error("merge indexes out of step");

	a_run_available: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_step |-> (a_ok || b_ok))
		else $error("merge step with both runs exhausted");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NK))
		else $error("batch count beyond store depth");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bottom_up_merge_sorter.sv
// Loading accepts a key while key_valid is high; a key marked last or the key that fills the store
// starts the sort. Sort of n keys: ceil(log2 n) passes, each priming and merging every segment.
// Output: after a prime step, one key per cycle while sorted_stall is low.
// The shared two-read-port merge unit places one key per cycle.
// Reset clears control and config to zero.
`timescale 1ns / 1ps
`default_nettype none

module bottom_up_merge_sorter (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  key_valid,
	output logic                                       key_stall,
	input  wire bumsort_pkg::key_item_t                key,
	output logic                                       sorted_valid,
	input  wire logic                                  sorted_stall,
	output bumsort_pkg::sorted_item_t                  sorted,
	input  wire logic                                  cfg_we,
	input  wire logic [bumsort_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bumsort_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                      descending_q;
	logic                      signed_keys_q;
	logic                      sorted_valid_q;
	bumsort_pkg::sorted_item_t sorted_q;
	bumsort_pkg::dp_cmd_t      cmd;
	bumsort_pkg::dp_stat_t     stat;
	bumsort_pkg::sorted_item_t rd_item;
	logic                      out_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q  <= 1'b0;
			signed_keys_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bumsort_pkg::CFG_DESCENDING:  descending_q  <= cfg_data[0];
				bumsort_pkg::CFG_SIGNED_KEYS: signed_keys_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// output register takes a new key when it is empty or its held key is taken
	assign out_room = !sorted_valid_q || !sorted_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			sorted_valid_q <= 1'b1;
		end else if (!sorted_stall) begin
			sorted_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_push) begin
			sorted_q <= rd_item;
		end
	end

	assign sorted_valid = sorted_valid_q;
	assign sorted       = sorted_q;

	bumsort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.out_room  (out_room),
		.stat      (stat),
		.cmd       (cmd)
	);

	bumsort_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key         (key),
		.descending  (descending_q),
		.signed_keys (signed_keys_q),
		.stat        (stat),
		.rd_item     (rd_item)
	);

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bumsort_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int HOLD_CYCLES = 800;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         key_valid = 1'b0;
	logic         key_stall;
	key_item_t    key = '0;
	logic         sorted_valid;
	logic         sorted_stall = 1'b0;
	sorted_item_t sorted;
	logic         cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_DESCENDING;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// sort order as the block should hold it
	bit order_desc = 1'b0;
	bit order_signed = 1'b0;

	key_item_t              key_backlog[$];
	logic [KEY_WIDTH-1:0]   batch_keys[$];
	sorted_item_t           sorted_expect[$];

	bit quiet = 1'b0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int failures = 0;
	int cycle_count = 0;

	bottom_up_merge_sorter uut (
		.clk(clk),
		.arst_n(arst_n),
		.key_valid(key_valid),
		.key_stall(key_stall),
		.key(key),
		.sorted_valid(sorted_valid),
		.sorted_stall(sorted_stall),
		.sorted(sorted),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// true when a may go ahead of b in the current order; ties keep a first
	function automatic bit key_ahead(input logic [KEY_WIDTH-1:0] a, input logic [KEY_WIDTH-1:0] b);
		logic [KEY_WIDTH-1:0] x;
		logic [KEY_WIDTH-1:0] y;
		x = a;
		y = b;
		if (order_signed) begin
			x[KEY_WIDTH-1] = ~x[KEY_WIDTH-1];
			y[KEY_WIDTH-1] = ~y[KEY_WIDTH-1];
		end
		return order_desc ? (x >= y) : (x <= y);
	endfunction

	// collect one key; on batch end, sort stably and queue the expected keys
	task automatic load_key(input key_item_t item);
		logic [KEY_WIDTH-1:0] ordered[$];
		sorted_item_t res;
		int pos;
		batch_keys.push_back(KEY_WIDTH'(item.key_value));
		if (item.key_last || batch_keys.size() >= MAX_KEYS) begin
			foreach (batch_keys[i]) begin
				pos = ordered.size();
				while (pos > 0 && !key_ahead(ordered[pos-1], batch_keys[i]))
					pos--;
				ordered.insert(pos, batch_keys[i]);
			end
			foreach (ordered[i]) begin
				res.sorted_value = 32'(ordered[i]);
				res.sorted_last = (i == ordered.size() - 1);
				sorted_expect.push_back(res);
			end
			batch_keys.delete();
		end
	endtask

	function automatic logic [31:0] draw_key();
		logic [31:0] corner[6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h1, 32'hFFFF_FFFE};
		case ($urandom_range(0, 9))
			0: return corner[$urandom_range(0, 5)];
			1, 2, 3: return 32'($urandom_range(0, 15));
			4: return 32'h7FFF_FFF8 + 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_batch(input int n, input bit mark_end);
		key_item_t item;
		for (int i = 0; i < n; i++) begin
			item.key_value = draw_key();
			item.key_last = (i == n - 1) ? mark_end : 1'b0;
			key_backlog.push_back(item);
		end
	endtask

	task automatic queue_literal(input logic [31:0] vals[$]);
		key_item_t item;
		foreach (vals[i]) begin
			item.key_value = vals[i];
			item.key_last = (i == vals.size() - 1);
			key_backlog.push_back(item);
		end
	endtask

	task automatic wait_drained();
		while (key_backlog.size() != 0 || key_valid || sorted_expect.size() != 0)
			@(posedge clk);
		// let the block settle back into loading
		repeat (16) @(posedge clk);
	endtask

	task automatic write_order(input bit desc, input bit sgn);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DESCENDING;
		cfg_data <= CFG_DATA_W'(desc);
		@(posedge clk);
		order_desc = desc;
		cfg_index <= CFG_SIGNED_KEYS;
		cfg_data <= CFG_DATA_W'(sgn);
		@(posedge clk);
		order_signed = sgn;
		cfg_we <= 1'b0;
	endtask

	// sender: transfer keys from the backlog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid <= 1'b0;
			key <= '0;
		end else begin
			if (key_valid && !key_stall)
				load_key(key);
			if (!key_valid || !key_stall) begin
				if (key_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
					key <= key_backlog.pop_front();
					key_valid <= 1'b1;
				end else begin
					key_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each transfer against the oldest expected key
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_stall <= 1'b0;
		end else begin
			if (sorted_valid && !sorted_stall) begin
				if (sorted_expect.size() == 0) begin
					$error("unexpected sorted key %h", sorted.sorted_value);
					failures++;
				end else begin
					if (sorted.sorted_value !== sorted_expect[0].sorted_value) begin
						$error("sorted_value expected %h actual %h",
							sorted_expect[0].sorted_value, sorted.sorted_value);
						failures++;
					end
					if (sorted.sorted_last !== sorted_expect[0].sorted_last) begin
						$error("sorted_last expected %b actual %b",
							sorted_expect[0].sorted_last, sorted.sorted_last);
						failures++;
					end
					void'(sorted_expect.pop_front());
				end
			end
			// long hold-off backs the block up into its input
			if (hold_left > 0) begin
				sorted_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_armed && !hold_done && sorted_valid) begin
				sorted_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				sorted_stall <= !quiet && ($urandom_range(0, 99) < 15);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("bottom_up_merge_sorter test failed");
			$finish;
		end
	end

	initial begin
		bit desc_set[4] = '{1'b1, 1'b0, 1'b1, 1'b0};
		bit sgn_set[4] = '{1'b0, 1'b1, 1'b1, 1'b0};
		int queued;
		int pick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single key, pair, extremes with repeats, small run of duplicates
		queue_literal('{32'hFFFF_FFFF});
		queue_literal('{32'hFFFF_FFFF, 32'h0});
		queue_literal('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
			32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5});
		queue_literal('{32'h3, 32'h3, 32'h8000_0001, 32'h3, 32'h0});
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_order(desc_set[ph], sgn_set[ph]);
			quiet = (ph == 2);
			hold_armed = (ph == 1);
			queued = 0;
			// full store: with the closing mark once, without it once
			if (ph == 1 || ph == 3) begin
				queue_batch(MAX_KEYS, ph == 3);
				queued += MAX_KEYS;
			end
			while (queued < 120) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					pick = $urandom_range(1, 8);
				else if (pick < 9)
					pick = $urandom_range(9, 40);
				else
					pick = $urandom_range(41, MAX_KEYS - 1);
				queue_batch(pick, 1'b1);
				queued += pick;
			end
			wait_drained();
		end

		repeat (64) @(posedge clk);
		if (failures == 0 && sorted_expect.size() == 0 && batch_keys.size() == 0)
			$display("bottom_up_merge_sorter test passed");
		else
			$display("bottom_up_merge_sorter test failed");
		$finish;
	end

endmodule
